// ===== rtl/core/dmv_pkg.sv =====
// Shared types and constants for the dataset mean/variance block.
// No dependencies; every other file of the block imports this package.
package dmv_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 8;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int SQ_W     = 2 * SAMPLE_W - 1 + $clog2(MAX_SAMPLES);
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 40;
  localparam int STATUS_W = 2;

  // n*sumsq - sum^2 and the shared divider
  localparam int NUM_W  = CNT_W + SQ_W;
  localparam int DIV_W  = NUM_W + FRAC_BITS;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [MEAN_W-1:0] MEAN_POS_SAT = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_NEG_SAT = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [VAR_W-1:0]  VAR_SAT      = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_SINGLE = 2'd1,
    ST_OVF    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUB,
    BK_MEAN_GO,
    BK_MEAN_WAIT,
    BK_VAR_GO,
    BK_VAR_WAIT,
    BK_OUT
  } back_state_t;

  // totals of one finished set, handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
    logic                    mode;
  } set_rec_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/dmv_ifs.sv =====
// Valid/ready channel interfaces for samples in and set results out.
// Depends on dmv_pkg for field widths.
interface dmv_in_if import dmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_of_set;

  modport source (output valid, output sample_value, output last_of_set, input ready);
  modport sink   (input valid, input sample_value, input last_of_set, output ready);
endinterface

interface dmv_out_if import dmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [VAR_W-1:0]         variance_q8;
  logic [CNT_W-1:0]         point_count;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output mean_q8, output variance_q8, output point_count,
                  output status, input ready);
  modport sink   (input valid, input mean_q8, input variance_q8, input point_count,
                  input status, output ready);
endinterface

// ===== rtl/core/dmv_front.sv =====
// Front end: accepts samples, keeps count/sum/sum of squares, holds the mode bit.
// Depends on dmv_pkg and dmv_in_if; pushes one set record per last sample.
module dmv_front import dmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  dmv_in_if.sink   in_ch,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     q_full,
  output logic     push,
  output set_rec_t push_rec
);

  logic                     mode_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [SQ_W-1:0]          sumsq_r, sumsq_nxt, sumsq_add;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_add;
  logic                     ovf_r, ovf_nxt, ovf_add;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                     accept;
  logic                     room;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign prod = in_ch.sample_value * in_ch.sample_value;
  assign room = cnt_r < CNT_W'(MAX_SAMPLES);

  // samples past the limit are dropped and flag the set
  always_comb begin
    sum_add   = room ? sum_r + SUM_W'(in_ch.sample_value) : sum_r;
    sumsq_add = room ? sumsq_r + SQ_W'(prod[2*SAMPLE_W-2:0]) : sumsq_r;
    cnt_add   = room ? cnt_r + CNT_W'(1) : cnt_r;
    ovf_add   = ovf_r | !room;
  end

  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_ch.last_of_set) begin
        sum_nxt   = '0;
        sumsq_nxt = '0;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        sum_nxt   = sum_add;
        sumsq_nxt = sumsq_add;
        cnt_nxt   = cnt_add;
        ovf_nxt   = ovf_add;
      end
    end
  end

  assign push           = accept && in_ch.last_of_set;
  assign push_rec.sum   = sum_add;
  assign push_rec.sumsq = sumsq_add;
  assign push_rec.cnt   = cnt_add;
  assign push_rec.ovf   = ovf_add;
  assign push_rec.mode  = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/core/dmv_queue.sv =====
// Short FIFO of finished-set records between front and back end.
// Depends on dmv_pkg for set_rec_t and depth.
module dmv_queue import dmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  set_rec_t push_rec,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output set_rec_t head
);

  set_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== rtl/core/dmv_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on dmv_pkg; shared by the mean and variance steps of the back end.
module dmv_div import dmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [DEN_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

// ===== rtl/core/dmv_back.sv =====
// Back end: per-set products, mean and variance divides, result register.
// Depends on dmv_pkg, dmv_out_if; drives the shared dmv_div through div_req_t.
module dmv_back import dmv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  set_rec_t   q_head,
  output logic       q_pop,
  output div_req_t   div_req,
  input  div_rsp_t   div_rsp,
  dmv_out_if.source  out_ch
);

  back_state_t             state_r, state_nxt;
  set_rec_t                rec_r;
  logic [SUM_W-1:0]        mag_r;
  logic [NUM_W-1:0]        nsq_r;
  logic [2*SUM_W-1:0]      sq_r;
  logic [DEN_W-1:0]        den_r;
  logic [NUM_W-1:0]        num_r;
  logic [MEAN_W-1:0]       mean_r;
  logic [VAR_W-1:0]        var_r;
  status_t                 status_r;
  logic [CNT_W-1:0]        dsr_cnt;
  logic [MEAN_W-1:0]       mean_fix;
  logic [VAR_W-1:0]        var_fix;
  logic                    neg;

  assign neg     = rec_r.sum[SUM_W-1];
  assign dsr_cnt = rec_r.mode ? rec_r.cnt - 1'b1 : rec_r.cnt;

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    if (neg) begin
      mean_fix = (div_rsp.quotient > DIV_W'(MEAN_NEG_SAT)) ? MEAN_NEG_SAT
                 : -div_rsp.quotient[MEAN_W-1:0];
    end else begin
      mean_fix = (div_rsp.quotient > DIV_W'(MEAN_POS_SAT)) ? MEAN_POS_SAT
                 : div_rsp.quotient[MEAN_W-1:0];
    end
    var_fix = (div_rsp.quotient > DIV_W'(VAR_SAT)) ? VAR_SAT
              : div_rsp.quotient[VAR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:      if (!q_empty) state_nxt = BK_MUL;
      BK_MUL:       state_nxt = rec_r.ovf ? BK_OUT : BK_SUB;
      BK_SUB:       state_nxt = BK_MEAN_GO;
      BK_MEAN_GO:   state_nxt = BK_MEAN_WAIT;
      BK_MEAN_WAIT: if (div_rsp.done) begin
        state_nxt = (status_r == ST_SINGLE) ? BK_OUT : BK_VAR_GO;
      end
      BK_VAR_GO:    state_nxt = BK_VAR_WAIT;
      BK_VAR_WAIT:  if (div_rsp.done) state_nxt = BK_OUT;
      BK_OUT:       if (out_ch.ready) state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    out_ch.valid     = 1'b0;
    case (state_r)
      BK_IDLE:    q_pop = !q_empty;
      BK_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mag_r) << FRAC_BITS;
        div_req.divisor  = DEN_W'(rec_r.cnt);
      end
      BK_VAR_GO:  begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(num_r) << FRAC_BITS;
        div_req.divisor  = den_r;
      end
      BK_OUT:     out_ch.valid = 1'b1;
      default:    q_pop = 1'b0;
    endcase
  end

  assign out_ch.mean_q8     = mean_r;
  assign out_ch.variance_q8 = var_r;
  assign out_ch.point_count = rec_r.cnt;
  assign out_ch.status      = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          rec_r <= q_head;
          mag_r <= q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
        end
      end
      BK_MUL: begin
        nsq_r  <= NUM_W'(rec_r.cnt) * NUM_W'(rec_r.sumsq);
        sq_r   <= (2*SUM_W)'(mag_r) * (2*SUM_W)'(mag_r);
        den_r  <= DEN_W'(rec_r.cnt) * DEN_W'(dsr_cnt);
        mean_r <= '0;
        var_r  <= '0;
        if (rec_r.ovf) begin
          status_r <= ST_OVF;
        end else if (rec_r.mode && rec_r.cnt < CNT_W'(2)) begin
          status_r <= ST_SINGLE;
        end else begin
          status_r <= ST_OK;
        end
      end
      BK_SUB:       num_r <= nsq_r - NUM_W'(sq_r);
      BK_MEAN_WAIT: if (div_rsp.done) mean_r <= mean_fix;
      BK_VAR_WAIT:  if (div_rsp.done) var_r <= var_fix;
      default:      num_r <= num_r;
    endcase
  end

endmodule

// ===== rtl/core/dataset_mean_variance.sv =====
// Top level of the dataset mean/variance block: front, set queue, back, divider.
// Depends on dmv_pkg, dmv_ifs, dmv_front, dmv_queue, dmv_div, dmv_back.
//
// Samples stream in one per cycle while the queue has room; the front end adds
// each into a running count, sum and sum of squares in the cycle it is accepted.
// The sample marked last closes the set: its totals go into a two-entry queue
// and the front starts the next set at once. The back end turns each queued set
// into one result: mean in Q.8 truncated toward zero, variance in Q.8 floored as
// (n*sumsq - sum^2)/(n*d), with d = n or n-1 per cfg_data. One shared restoring
// divider does both divisions at one bit per cycle; overflowed sets skip the
// divides. The back end takes one set at a time, so sets that close faster than
// it finishes them fill the queue and then in_ch.ready drops until it drains.
// Status 1 flags a single point in sample mode (variance 0); status 2 flags
// more than MAX_SAMPLES points (mean and variance 0, count MAX_SAMPLES).
module dataset_mean_variance import dmv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dmv_in_if.sink    in_ch,
  dmv_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  logic     push, pop, q_full, q_empty;
  set_rec_t push_rec, q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  dmv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  dmv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  dmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dmv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_OVF |->
      out_ch.mean_q8 == '0 && out_ch.variance_q8 == '0 &&
      out_ch.point_count == CNT_W'(MAX_SAMPLES))
    else $error("overflowed set result not zeroed");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_SINGLE |->
      out_ch.point_count == CNT_W'(1) && out_ch.variance_q8 == '0)
    else $error("single-point result malformed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.point_count != '0)
    else $error("result with zero points");

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !out_ch.valid)
    else $error("back end took a set while a result was pending");

endmodule
